[design/multi_slot_software_timer_unit_assert.svh]
// Assertion macros for the timer table.
`ifndef MULTI_SLOT_SOFTWARE_TIMER_UNIT_ASSERT_SVH
`define MULTI_SLOT_SOFTWARE_TIMER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mst_pkg.sv]
// Types and constants shared by the timer table modules.
package mst_pkg;

    localparam int SLOTS_DEFAULT = 8;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] KIND_STARTED = 2'd0;
    localparam logic [1:0] KIND_FULL    = 2'd1;
    localparam logic [1:0] KIND_FIRED   = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        now_ms;
        logic [15:0]        period_ms;
        logic [15:0]        repeat_limit;
        logic signed [15:0] user_value;
        logic [15:0]        target_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        timer_id;
        logic [15:0]        fire_count;
        logic signed [15:0] user_value_out;
        logic               finished;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [15:0]        period_ms;
        logic [31:0]        last_time;
        logic [15:0]        repeat_limit;
        logic [15:0]        fire_count;
        logic signed [15:0] user_value;
    } slot_rec_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_EVAL,
        ST_FLUSH
    } state_t;

endpackage

[design/mst_ram.sv]
// Slot record memory: one write port, one read port, registered read data.
module mst_ram #(
    parameter int DEPTH = mst_pkg::SLOTS_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               aclk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  mst_pkg::slot_rec_t wdata,
    input  logic [AW-1:0]      raddr,
    output mst_pkg::slot_rec_t rdata
);

    mst_pkg::slot_rec_t mem [DEPTH];
    mst_pkg::slot_rec_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/multi_slot_software_timer_unit.sv]
// Timer table top level: sequencer, slot flags and ids, result register.
// A start item returns one result; a clear stops every slot with a matching
// id at once; a tick walks the slot memory one slot per cycle while no fire
// waits on a full result register. A start, a fire that finds an earlier
// fire still held, and the final fire of a tick each wait while the result
// register is still occupied. The walk rate is
// set by the single read port of the slot memory. Fires come out in slot
// order, only the last one of a tick carries last = 1; a tick with nothing
// due and a clear give no result. New items are taken whenever the
// sequencer is idle, even while a result waits for m_ready.
`include "multi_slot_software_timer_unit_assert.svh"

module multi_slot_software_timer_unit #(
    parameter int SLOTS = mst_pkg::SLOTS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mst_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output mst_pkg::out_item_t m_item
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    mst_pkg::state_t    state_reg, state_next;
    mst_pkg::in_item_t  cmd_reg;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [SLOTS-1:0]   running_reg;
    logic [15:0]        id_reg [SLOTS];
    logic [15:0]        next_id_reg;
    logic               held_valid_reg;
    mst_pkg::out_item_t held_reg;
    logic               m_valid_reg;
    mst_pkg::out_item_t m_item_reg;

    logic               accept;
    logic               out_free;
    logic [IW-1:0]      free_idx;
    logic               free_found;
    logic               last_slot;
    logic [31:0]        elapsed;
    logic               due;
    logic [15:0]        new_count;
    logic               fin;
    logic               eval_go;
    logic [15:0]        issue_id;

    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    mst_pkg::slot_rec_t mem_wdata;
    logic [IW-1:0]      rd_addr;
    mst_pkg::slot_rec_t rd_rec;

    logic               out_load;
    mst_pkg::out_item_t out_data;
    logic               held_load;
    mst_pkg::out_item_t held_data;
    logic               held_clear;
    logic               claim;
    logic               stop;

    mst_ram #(
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (rd_rec)
    );

    assign s_ready  = (state_reg == mst_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign issue_id = 16'(next_id_reg + 16'd1);

    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!running_reg[i]) begin
                free_idx   = IW'(i);
                free_found = 1'b1;
            end
        end
    end

    assign last_slot = (idx_reg == IW'(SLOTS - 1));
    assign elapsed   = cmd_reg.now_ms - rd_rec.last_time;
    assign due       = running_reg[idx_reg] && (elapsed >= {16'd0, rd_rec.period_ms});
    assign new_count = 16'(rd_rec.fire_count + 16'd1);
    assign fin       = (rd_rec.repeat_limit != 16'd0) && (rd_rec.repeat_limit == new_count);
    assign eval_go   = (state_reg == mst_pkg::ST_EVAL) && (!due || !held_valid_reg || out_free);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mst_pkg::ST_IDLE: begin
                if (accept && s_item.opcode == mst_pkg::OP_START) begin
                    state_next = mst_pkg::ST_START;
                end else if (accept && s_item.opcode == mst_pkg::OP_TICK) begin
                    state_next = mst_pkg::ST_EVAL;
                end
            end
            mst_pkg::ST_START: begin
                if (out_free) begin
                    state_next = mst_pkg::ST_IDLE;
                end
            end
            mst_pkg::ST_EVAL: begin
                if (eval_go && last_slot) begin
                    state_next = mst_pkg::ST_FLUSH;
                end
            end
            mst_pkg::ST_FLUSH: begin
                if (!held_valid_reg || out_free) begin
                    state_next = mst_pkg::ST_IDLE;
                end
            end
            default: state_next = mst_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = rd_rec;
        rd_addr    = '0;
        idx_next   = idx_reg;
        out_load   = 1'b0;
        out_data   = '0;
        held_load  = 1'b0;
        held_data  = '0;
        held_clear = 1'b0;
        claim      = 1'b0;
        stop       = 1'b0;
        case (state_reg)
            mst_pkg::ST_IDLE: begin
                idx_next = '0;
            end
            mst_pkg::ST_START: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_data.last = 1'b1;
                    if (free_found) begin
                        claim                  = 1'b1;
                        mem_we                 = 1'b1;
                        mem_waddr              = free_idx;
                        mem_wdata.period_ms    = cmd_reg.period_ms;
                        mem_wdata.last_time    = cmd_reg.now_ms;
                        mem_wdata.repeat_limit = cmd_reg.repeat_limit;
                        mem_wdata.fire_count   = 16'd0;
                        mem_wdata.user_value   = cmd_reg.user_value;
                        out_data.kind          = mst_pkg::KIND_STARTED;
                        out_data.timer_id      = issue_id;
                    end else begin
                        out_data.kind = mst_pkg::KIND_FULL;
                    end
                end
            end
            mst_pkg::ST_EVAL: begin
                rd_addr = (eval_go && !last_slot) ? IW'(idx_reg + 1'b1) : idx_reg;
                if (eval_go) begin
                    if (!last_slot) begin
                        idx_next = IW'(idx_reg + 1'b1);
                    end
                    if (due) begin
                        mem_we                   = 1'b1;
                        mem_wdata.last_time      = cmd_reg.now_ms;
                        mem_wdata.fire_count     = new_count;
                        stop                     = fin;
                        held_load                = 1'b1;
                        held_data.kind           = mst_pkg::KIND_FIRED;
                        held_data.timer_id       = id_reg[idx_reg];
                        held_data.fire_count     = new_count;
                        held_data.user_value_out = rd_rec.user_value;
                        held_data.finished       = fin;
                        if (held_valid_reg) begin
                            out_load = 1'b1;
                            out_data = held_reg;
                        end
                    end
                end
            end
            mst_pkg::ST_FLUSH: begin
                if (held_valid_reg && out_free) begin
                    out_load      = 1'b1;
                    out_data      = held_reg;
                    out_data.last = 1'b1;
                    held_clear    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= mst_pkg::ST_IDLE;
            idx_reg        <= '0;
            running_reg    <= '0;
            next_id_reg    <= '0;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                id_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (accept && s_item.opcode == mst_pkg::OP_CLEAR) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (id_reg[i] == s_item.target_id) begin
                        running_reg[i] <= 1'b0;
                    end
                end
            end
            if (claim) begin
                running_reg[free_idx] <= 1'b1;
                id_reg[free_idx]      <= issue_id;
                next_id_reg           <= issue_id;
            end
            if (stop) begin
                running_reg[idx_reg] <= 1'b0;
            end
            if (held_load) begin
                held_valid_reg <= 1'b1;
            end else if (held_clear) begin
                held_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_item;
        end
        if (held_load) begin
            held_reg <= held_data;
        end
        if (out_load) begin
            m_item_reg <= out_data;
        end
    end

    `MST_ASSERT_NOW(a_no_overwrite, out_load, out_free, "result register overwritten")
    `MST_ASSERT_NOW(a_held_kept, held_load && held_valid_reg, out_load, "held fire dropped")
    `MST_ASSERT_NOW(a_idle_empty, s_ready, !held_valid_reg, "idle with a pending fire")
    `MST_ASSERT_NEXT(a_tick_walk, accept && s_item.opcode == mst_pkg::OP_TICK,
        state_reg == mst_pkg::ST_EVAL && idx_reg == '0, "tick did not start walk")

endmodule
